/* hdl/lru_block_cache_unit_assert.svh */
// Assertion macros shared by the cache RTL.
`ifndef LRU_BLOCK_CACHE_UNIT_ASSERT_SVH
`define LRU_BLOCK_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbc assertion failed");

// Next-cycle implication, held off during reset.
`define LBC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbc assertion failed");

`endif

/* hdl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared constants and types of the LRU block cache.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int ENTRIES     = 64;
  localparam int BLOCK_WORDS = 32;
  localparam int LINE_W      = $clog2(ENTRIES);
  localparam int RANK_W      = LINE_W;
  localparam int FILL_W      = LINE_W + 1;
  localparam int BW_W        = $clog2(BLOCK_WORDS);
  localparam int WIDX_W      = 5;
  localparam int ADDR_W      = LINE_W + BW_W;
  localparam int DEPTH       = ENTRIES * BLOCK_WORDS;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic [7:0]  dev;
    logic [15:0] sec;
    logic [15:0] blk;
  } tag_t;

  // Update broadcast to all cells on a put's first word.
  typedef struct packed {
    logic              en;
    logic              touch;    // shift down newer lines
    logic              set_tag;
    logic [LINE_W-1:0] line;
    logic [RANK_W-1:0] old_rank;
    logic [RANK_W-1:0] new_rank;
  } cell_upd_t;

  typedef struct packed {
    logic              hit;
    logic [LINE_W-1:0] hit_line;
    logic [RANK_W-1:0] hit_rank;
    logic [LINE_W-1:0] vic_line;
  } look_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_MISS,
    S_READ,
    S_LOAD
  } state_t;

endpackage

/* hdl/lbc_if.sv */
// ----------------------------------------------------------------------------
// lbc_in_if / lbc_out_if
// Valid/ready channels of the LRU block cache.
// ----------------------------------------------------------------------------
interface lbc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  device_id;
  logic [15:0] sector;
  logic [15:0] block_number;
  logic [4:0]  word_index;
  logic [63:0] data_word;
  modport source (output valid, operation, device_id, sector, block_number,
                  word_index, data_word, input ready);
  modport sink (input valid, operation, device_id, sector, block_number,
                word_index, data_word, output ready);
endinterface

interface lbc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [4:0]  out_index;
  logic [63:0] out_word;
  logic        last;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  modport source (output valid, hit, out_index, out_word, last, hit_total,
                  miss_total, input ready);
  modport sink (input valid, hit, out_index, out_word, last, hit_total,
                miss_total, output ready);
endinterface

/* hdl/lbc_cell.sv */
// ----------------------------------------------------------------------------
// lbc_cell
// One cache line directory entry: valid, tag and recency rank.
// ----------------------------------------------------------------------------
module lbc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lbc_pkg::LINE_W-1:0] idx,
  input  lbc_pkg::tag_t             query,
  input  lbc_pkg::cell_upd_t        upd,
  output logic                      match,
  output logic                      oldest,
  output logic [lbc_pkg::RANK_W-1:0] rank
);

  logic          valid;
  lbc_pkg::tag_t tag;

  assign match  = valid && (tag == query);
  assign oldest = valid && (rank == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      if (upd.line == idx) begin
        valid <= 1'b1;
        rank  <= upd.new_rank;
      end else if (upd.touch && valid && rank > upd.old_rank) begin
        rank <= rank - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.set_tag && upd.line == idx) begin
      tag <= query;
    end
  end

endmodule

/* hdl/lbc_cell_row.sv */
// ----------------------------------------------------------------------------
// lbc_cell_row
// Row of directory cells with hit and victim encoding.
// ----------------------------------------------------------------------------
`include "lru_block_cache_unit_assert.svh"

module lbc_cell_row (
  input  logic               clk,
  input  logic               rst,
  input  lbc_pkg::tag_t      query,
  input  lbc_pkg::cell_upd_t upd,
  output lbc_pkg::look_t     look
);

  logic [lbc_pkg::ENTRIES-1:0] match;
  logic [lbc_pkg::ENTRIES-1:0] oldest;
  logic [lbc_pkg::RANK_W-1:0]  rank [lbc_pkg::ENTRIES];

  for (genvar i = 0; i < lbc_pkg::ENTRIES; i++) begin : g_cell
    lbc_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .idx    (lbc_pkg::LINE_W'(i)),
      .query  (query),
      .upd    (upd),
      .match  (match[i]),
      .oldest (oldest[i]),
      .rank   (rank[i])
    );
  end

  // Tags are unique among valid lines, so an OR of the selected fields works.
  always_comb begin
    look = '0;
    look.hit = |match;
    for (int i = 0; i < lbc_pkg::ENTRIES; i++) begin
      if (match[i]) begin
        look.hit_line = look.hit_line | lbc_pkg::LINE_W'(i);
        look.hit_rank = look.hit_rank | rank[i];
      end
      if (oldest[i]) begin
        look.vic_line = look.vic_line | lbc_pkg::LINE_W'(i);
      end
    end
  end

  `LBC_ASSERT_IMP(a_one_match, clk, rst, 1'b1, $onehot0(match))
  `LBC_ASSERT_IMP(a_one_oldest, clk, rst, 1'b1, $onehot0(oldest))
  `LBC_ASSERT_IMP(a_victim_found, clk, rst, upd.en && upd.touch && upd.set_tag, |oldest)

endmodule

/* hdl/lru_block_cache_unit.sv */
// ----------------------------------------------------------------------------
// lru_block_cache_unit
// Fully associative LRU cache of 32-word blocks.
// ----------------------------------------------------------------------------
// channel  dir  content
// in_ch    in   get, or one put word, with block tag
// out_ch   out  one get result word (hit) or miss result
//
// Each item is accepted in S_IDLE, then looked up in the directory in S_LOOK.
// A get hit streams 32 words from the registered data RAM via S_READ/S_LOAD.
// A miss result waits in S_MISS until the output register is free.
// Synchronous reset clears directory valid bits, ranks and counters.
// Output stalls hold a get's results; input is taken only when idle.
`include "lru_block_cache_unit_assert.svh"

module lru_block_cache_unit (
  input  logic      clk,
  input  logic      rst,
  lbc_in_if.sink    in_ch,
  lbc_out_if.source out_ch
);

  lbc_pkg::state_t state, state_next;

  logic                       op;
  lbc_pkg::tag_t              qtag;
  logic [4:0]                 widx;
  logic [63:0]                wdata;
  logic [lbc_pkg::FILL_W-1:0] fill_count;
  logic [lbc_pkg::LINE_W-1:0] put_line;
  logic [lbc_pkg::LINE_W-1:0] get_line;
  logic [lbc_pkg::BW_W-1:0]   k;
  logic [31:0]                hit_cnt, miss_cnt;
  logic [63:0]                mem [lbc_pkg::DEPTH];
  logic [63:0]                rd_data;

  lbc_pkg::cell_upd_t         upd;
  lbc_pkg::look_t             look;
  logic [lbc_pkg::LINE_W-1:0] wline;
  logic                       out_free;

  lbc_cell_row u_row (
    .clk   (clk),
    .rst   (rst),
    .query (qtag),
    .upd   (upd),
    .look  (look)
  );

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == lbc_pkg::S_IDLE) && !rst;

  // Line choice for a put's first word.
  always_comb begin
    upd = '0;
    if (state == lbc_pkg::S_LOOK && op == lbc_pkg::OP_PUT && widx == '0) begin
      upd.en = 1'b1;
      if (look.hit) begin
        upd.touch    = 1'b1;
        upd.line     = look.hit_line;
        upd.old_rank = look.hit_rank;
        upd.new_rank = lbc_pkg::RANK_W'(fill_count - 1'b1);
      end else if (fill_count < lbc_pkg::FILL_W'(lbc_pkg::ENTRIES)) begin
        upd.set_tag  = 1'b1;
        upd.line     = fill_count[lbc_pkg::LINE_W-1:0];
        upd.new_rank = fill_count[lbc_pkg::RANK_W-1:0];
      end else begin
        upd.touch    = 1'b1;
        upd.set_tag  = 1'b1;
        upd.line     = look.vic_line;
        upd.new_rank = lbc_pkg::RANK_W'(lbc_pkg::ENTRIES - 1);
      end
    end
    wline = upd.en ? upd.line : put_line;
  end

  always_comb begin
    state_next = state;
    case (state)
      lbc_pkg::S_IDLE: if (in_ch.valid) state_next = lbc_pkg::S_LOOK;
      lbc_pkg::S_LOOK: begin
        if (op == lbc_pkg::OP_PUT) state_next = lbc_pkg::S_IDLE;
        else if (look.hit)         state_next = lbc_pkg::S_READ;
        else                       state_next = lbc_pkg::S_MISS;
      end
      lbc_pkg::S_MISS: if (out_free) state_next = lbc_pkg::S_IDLE;
      lbc_pkg::S_READ: if (out_free) state_next = lbc_pkg::S_LOAD;
      lbc_pkg::S_LOAD: begin
        state_next = (k == lbc_pkg::BW_W'(lbc_pkg::BLOCK_WORDS - 1))
                     ? lbc_pkg::S_IDLE : lbc_pkg::S_READ;
      end
      default: state_next = lbc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lbc_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Item capture and data RAM.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op    <= in_ch.operation;
      qtag  <= '{dev: in_ch.device_id, sec: in_ch.sector, blk: in_ch.block_number};
      widx  <= in_ch.word_index;
      wdata <= in_ch.data_word;
    end
    if (state == lbc_pkg::S_LOOK && op == lbc_pkg::OP_PUT &&
        int'(widx) < lbc_pkg::BLOCK_WORDS) begin
      mem[{wline, widx[lbc_pkg::BW_W-1:0]}] <= wdata;
    end
    if (state == lbc_pkg::S_READ && out_free) begin
      rd_data <= mem[{get_line, k}];
    end
    if (state == lbc_pkg::S_LOOK) get_line <= look.hit_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      put_line   <= '0;
      hit_cnt    <= '0;
      miss_cnt   <= '0;
      k          <= '0;
    end else begin
      if (upd.en) begin
        put_line <= upd.line;
        if (!look.hit && fill_count < lbc_pkg::FILL_W'(lbc_pkg::ENTRIES)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (state == lbc_pkg::S_LOOK && op == lbc_pkg::OP_GET) begin
        k <= '0;
        if (look.hit) begin
          if (hit_cnt != '1) hit_cnt <= hit_cnt + 1'b1;
        end else if (miss_cnt != '1) begin
          miss_cnt <= miss_cnt + 1'b1;
        end
      end
      if (state == lbc_pkg::S_LOAD) k <= k + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else begin
      if ((state == lbc_pkg::S_MISS && out_free) || state == lbc_pkg::S_LOAD) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lbc_pkg::S_MISS && out_free) begin
      out_ch.hit        <= 1'b0;
      out_ch.out_index  <= '0;
      out_ch.out_word   <= '0;
      out_ch.last       <= 1'b1;
      out_ch.hit_total  <= hit_cnt;
      out_ch.miss_total <= miss_cnt;
    end else if (state == lbc_pkg::S_LOAD) begin
      out_ch.hit        <= 1'b1;
      out_ch.out_index  <= 5'(k);
      out_ch.out_word   <= rd_data;
      out_ch.last       <= (k == lbc_pkg::BW_W'(lbc_pkg::BLOCK_WORDS - 1));
      out_ch.hit_total  <= hit_cnt;
      out_ch.miss_total <= miss_cnt;
    end
  end

  `LBC_ASSERT_IMP(a_miss_zero, clk, rst, out_ch.valid && !out_ch.hit,
                  out_ch.last && out_ch.out_word == '0 && out_ch.out_index == '0)
  `LBC_ASSERT_NXT(a_hit_mono, clk, rst, 1'b1, hit_cnt >= $past(hit_cnt))
  `LBC_ASSERT_NXT(a_load_free, clk, rst, state == lbc_pkg::S_READ && out_free,
                  !out_ch.valid)

endmodule

/* verif/lbc_checker.sv */
// ----------------------------------------------------------------------------
// lbc_checker
// Watches both channels of the LRU block cache, predicts every get result
// from accepted transactions and compares each output transaction with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lbc_checker (
  input  logic        clk,
  input  logic        rst,
  lbc_in_if.sink      in_mon,
  lbc_out_if.sink     out_mon,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        hit;
    logic [4:0]  idx;
    logic [63:0] word;
    logic        last;
    logic [31:0] hits;
    logic [31:0] misses;
  } get_result_t;

  logic              vld   [lbc_pkg::ENTRIES];
  lbc_pkg::tag_t     tags  [lbc_pkg::ENTRIES];
  int unsigned       rank  [lbc_pkg::ENTRIES];
  logic [63:0]       words [lbc_pkg::DEPTH];
  int unsigned       fill;
  int unsigned       cur_line;
  logic [31:0]       hit_cnt;
  logic [31:0]       miss_cnt;
  get_result_t       result_q[$];

  assign pending = result_q.size();

  function automatic int lookup(lbc_pkg::tag_t t);
    for (int i = 0; i < lbc_pkg::ENTRIES; i++)
      if (vld[i] && tags[i] == t) return i;
    return -1;
  endfunction

  function automatic void make_recent(int unsigned ln);
    int unsigned old;
    old = rank[ln];
    for (int j = 0; j < lbc_pkg::ENTRIES; j++)
      if (j != ln && vld[j] && rank[j] > old) rank[j]--;
    rank[ln] = fill - 1;
  endfunction

  function automatic void predict(logic op, lbc_pkg::tag_t t, logic [4:0] widx,
                                  logic [63:0] d);
    int f;
    int unsigned ln;
    get_result_t r;
    if (op == lbc_pkg::OP_PUT) begin
      if (widx == 0) begin
        f = lookup(t);
        if (f >= 0) begin
          ln = f;
          make_recent(ln);
        end else begin
          if (fill < lbc_pkg::ENTRIES) begin
            ln = fill;
            vld[ln] = 1'b1;
            fill++;
            rank[ln] = fill - 1;
          end else begin
            ln = 0;
            for (int j = 1; j < lbc_pkg::ENTRIES; j++)
              if (rank[j] < rank[ln]) ln = j;
            make_recent(ln);
          end
          tags[ln] = t;
        end
        cur_line = ln;
      end
      if (widx < lbc_pkg::BLOCK_WORDS) words[cur_line * lbc_pkg::BLOCK_WORDS + widx] = d;
      return;
    end
    f = lookup(t);
    if (f < 0) begin
      if (miss_cnt != '1) miss_cnt++;
      r = '{hit: 1'b0, idx: '0, word: '0, last: 1'b1, hits: hit_cnt, misses: miss_cnt};
      result_q.push_back(r);
    end else begin
      if (hit_cnt != '1) hit_cnt++;
      for (int k = 0; k < lbc_pkg::BLOCK_WORDS; k++) begin
        r = '{hit: 1'b1, idx: k[4:0], word: words[f * lbc_pkg::BLOCK_WORDS + k],
              last: (k == lbc_pkg::BLOCK_WORDS - 1), hits: hit_cnt, misses: miss_cnt};
        result_q.push_back(r);
      end
    end
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    get_result_t e;
    if (rst) begin
      for (int i = 0; i < lbc_pkg::ENTRIES; i++) begin
        vld[i] = 1'b0;
        rank[i] = 0;
      end
      for (int i = 0; i < lbc_pkg::DEPTH; i++) words[i] = '0;
      fill = 0;
      cur_line = 0;
      hit_cnt = '0;
      miss_cnt = '0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          report("unexpected transaction", 64'({out_mon.hit, out_mon.out_index}), '0);
        end else begin
          e = result_q.pop_front();
          if (out_mon.hit !== e.hit) report("hit", 64'(out_mon.hit), 64'(e.hit));
          if (out_mon.out_index !== e.idx)
            report("out_index", 64'(out_mon.out_index), 64'(e.idx));
          if (out_mon.out_word !== e.word) report("out_word", out_mon.out_word, e.word);
          if (out_mon.last !== e.last) report("last", 64'(out_mon.last), 64'(e.last));
          if (out_mon.hit_total !== e.hits)
            report("hit_total", 64'(out_mon.hit_total), 64'(e.hits));
          if (out_mon.miss_total !== e.misses)
            report("miss_total", 64'(out_mon.miss_total), 64'(e.misses));
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict(in_mon.operation,
                '{dev: in_mon.device_id, sec: in_mon.sector, blk: in_mon.block_number},
                in_mon.word_index, in_mon.data_word);
    end
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives gets and block puts into the LRU block cache with random idling
// and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycle_cnt = 0;
  bit   quiet = 1'b0;      // no idling in the last part of the run
  bit   hold_long = 1'b0;

  lbc_in_if  in_ch ();
  lbc_out_if out_ch ();

  lru_block_cache_unit i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  lbc_checker i_chk (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                     .fail_count(fail_count), .pending(pending));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL lru_block_cache_unit");
      $finish;
    end
  end

  // tags written so far, so gets mostly target blocks that are whole
  lbc_pkg::tag_t known_tags[$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = lbc_pkg::OP_GET;
    in_ch.device_id = '0;
    in_ch.sector = '0;
    in_ch.block_number = '0;
    in_ch.word_index = '0;
    in_ch.data_word = '0;
    out_ch.ready = 1'b0;
  end

  task automatic send(logic op, lbc_pkg::tag_t t, logic [4:0] widx, logic [63:0] d);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.device_id = t.dev;
    in_ch.sector = t.sec;
    in_ch.block_number = t.blk;
    in_ch.word_index = widx;
    in_ch.data_word = d;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic put_block(lbc_pkg::tag_t t, bit patterned);
    for (int w = 0; w < lbc_pkg::BLOCK_WORDS; w++)
      send(lbc_pkg::OP_PUT, t, w[4:0],
           patterned ? {t, w[23:0]} : {$urandom, $urandom});
    known_tags.push_back(t);
  endtask

  function automatic lbc_pkg::tag_t rand_tag();
    return '{dev: 8'($urandom_range(0, 3)), sec: 16'($urandom_range(0, 3)),
             blk: 16'($urandom)};
  endfunction

  // tags of lines that only get word 0; never the target of a get
  function automatic lbc_pkg::tag_t fill_tag();
    return '{dev: 8'($urandom_range(64, 67)), sec: 16'($urandom), blk: 16'($urandom)};
  endfunction

  // output side: random stall bursts, one long hold-off
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        gap = $urandom_range(1, 17);
        repeat (gap) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    lbc_pkg::tag_t t;
    int            wait_cnt;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: miss on empty, extremes of tag fields, hits, stray words
    send(lbc_pkg::OP_GET, '{dev: 8'hff, sec: 16'hffff, blk: 16'hffff}, 5'd31, '1);
    send(lbc_pkg::OP_PUT, '{dev: 8'h00, sec: 16'h0000, blk: 16'h0000}, 5'd7, 64'hdead);
    put_block('{dev: 8'hff, sec: 16'hffff, blk: 16'hffff}, 1'b0);
    put_block('{dev: 8'h00, sec: 16'h0000, blk: 16'h0000}, 1'b1);
    send(lbc_pkg::OP_GET, '{dev: 8'hff, sec: 16'hffff, blk: 16'hffff}, 5'd0, '0);
    send(lbc_pkg::OP_GET, '{dev: 8'h00, sec: 16'h0000, blk: 16'h0000}, 5'd0, '0);
    send(lbc_pkg::OP_PUT, '{dev: 8'h11, sec: 16'h0, blk: 16'h0}, 5'd31, '1);
    send(lbc_pkg::OP_GET, '{dev: 8'h00, sec: 16'h0000, blk: 16'h0000}, 5'd0, '0);
    send(lbc_pkg::OP_GET, '{dev: 8'h00, sec: 16'h0001, blk: 16'h0000}, 5'd0, '0);

    // pressure: receiver holds off while gets keep coming
    hold_long = 1'b1;
    repeat (4)
      send(lbc_pkg::OP_GET, '{dev: 8'hff, sec: 16'hffff, blk: 16'hffff}, 5'd0, '0);

    // fill past capacity with single-word puts so evictions follow LRU;
    // one rewrite midway keeps its block resident
    for (int n = 0; n < 66; n++) begin
      if (n == 30) put_block('{dev: 8'hff, sec: 16'hffff, blk: 16'hffff}, 1'b1);
      send(lbc_pkg::OP_PUT, fill_tag(), 5'd0, {$urandom, $urandom});
      if ($urandom_range(0, 5) == 0)
        send(lbc_pkg::OP_GET, known_tags[$urandom_range(0, known_tags.size() - 1)],
             '0, '0);
    end

    for (int n = 0; n < 20; n++) begin
      if (n == 14) quiet = 1'b1;
      case ($urandom_range(0, 19)) inside
        [0:9]: send(lbc_pkg::OP_GET, known_tags[$urandom_range(0, known_tags.size() - 1)],
                    5'($urandom), {$urandom, $urandom});
        [10:11]: send(lbc_pkg::OP_GET, rand_tag(), 5'($urandom), {$urandom, $urandom});
        [12:15]: send(lbc_pkg::OP_PUT, fill_tag(), 5'd0, {$urandom, $urandom});
        [16:18]: send(lbc_pkg::OP_PUT, rand_tag(), 5'($urandom_range(1, 31)),
                      {$urandom, $urandom});
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            t = known_tags[$urandom_range(0, known_tags.size() - 1)];
            put_block(t, 1'b0);  // rewrite of a resident or evicted block
          end else begin
            put_block(rand_tag(), 1'b0);
          end
        end
      endcase
    end

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS lru_block_cache_unit");
    end else begin
      $display("FAIL lru_block_cache_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lbc_pkg.sv
hdl/lbc_if.sv
hdl/lbc_cell.sv
hdl/lbc_cell_row.sv
hdl/lru_block_cache_unit.sv
verif/lbc_checker.sv
verif/tb_top.sv
